/* design/idll_pkg.sv */
// shared types and constants for the indexed doubly linked list engine
package idll_pkg;

   localparam int SlotBits = 8;
   localparam int ValueBits = 32;
   localparam int Capacity = 255;

   typedef logic [SlotBits-1:0] slot_type;
   typedef logic [ValueBits-1:0] value_type;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT   = 3'd0,
      OP_PUSH_BACK    = 3'd1,
      OP_INSERT_BEFORE = 3'd2,
      OP_INSERT_AFTER = 3'd3,
      OP_DELETE       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD_POS  = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic clear_init;  // step free chain init sweep
      logic walk_read;   // issue next link read for walk
      logic walk_step;   // advance walk cursor from read data
      logic link_read;   // read prev/next of anchor
      logic commit;      // apply link updates
      logic fail_full;
      logic fail_pos;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_done;
      logic pos_bad;
      logic is_full;
      logic needs_pos;
      logic is_valid_op;
      logic walk_done;
   } sts_type;

endpackage

/* design/idll_ctrl.sv */
// controller state machine for the list engine
module idll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_free,
   input  idll_pkg::sts_type  sts,
   output idll_pkg::cmd_type  cmd,
   output logic               req_tready,
   output logic               rsp_load
);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_WREAD  = 7'b0001000,
      S_WSTEP  = 7'b0010000,
      S_LREAD  = 7'b0100000,
      S_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else state_ff <= state_in;
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clear_init = 1'b1;
            if (sts.init_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.is_valid_op) begin
               if (rsp_free) begin
                  rsp_load = 1'b1; state_in = S_IDLE;
               end
            end else if (sts.needs_pos && sts.pos_bad) begin
               if (rsp_free) begin
                  cmd.fail_pos = 1'b1; rsp_load = 1'b1; state_in = S_IDLE;
               end
            end else if (sts.is_full) begin
               if (rsp_free) begin
                  cmd.fail_full = 1'b1; rsp_load = 1'b1; state_in = S_IDLE;
               end
            end else if (sts.needs_pos) begin
               state_in = sts.walk_done ? S_LREAD : S_WREAD;
            end else begin
               state_in = S_LREAD;
            end
         end
         S_WREAD: begin
            if (sts.walk_done) begin
               state_in = S_LREAD;
            end else begin
               cmd.walk_read = 1'b1;
               state_in = S_WSTEP;
            end
         end
         S_WSTEP: begin
            cmd.walk_step = 1'b1;
            state_in = S_WREAD;
         end
         S_LREAD: begin
            cmd.link_read = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

endmodule

/* design/idll_dpath.sv */
// slot arrays, head/tail/free registers and walk cursor of the list engine
module idll_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  idll_pkg::cmd_type       cmd,
   input  logic [2:0]              req_operation,
   input  idll_pkg::value_type     req_value,
   input  idll_pkg::slot_type      req_position,
   output idll_pkg::sts_type       sts,
   output logic [1:0]              res_status,
   output idll_pkg::slot_type      res_slot,
   output idll_pkg::value_type     res_element,
   output idll_pkg::slot_type      res_count
);

   idll_pkg::value_type values_mem [0:idll_pkg::Capacity];
   idll_pkg::slot_type  next_mem   [0:idll_pkg::Capacity];
   idll_pkg::slot_type  prev_mem   [0:idll_pkg::Capacity];
   idll_pkg::slot_type  free_mem   [0:idll_pkg::Capacity];

   idll_pkg::slot_type head_ff, tail_ff, free_head_ff, count_ff;
   idll_pkg::slot_type init_ff;
   logic init_done_ff;
   logic [2:0] op_ff;
   idll_pkg::value_type value_ff;
   idll_pkg::slot_type pos_ff, walk_idx_ff, cursor_ff;

   // registered reads
   idll_pkg::slot_type walk_rd_ff, anc_prev_ff, anc_next_ff, free_nx_ff;
   idll_pkg::value_type anc_val_ff;

   logic is_del;
   assign is_del = (op_ff == idll_pkg::OP_DELETE);

   assign sts.init_done = init_done_ff;
   assign sts.is_valid_op = (op_ff <= idll_pkg::OP_DELETE);
   assign sts.needs_pos = (op_ff == idll_pkg::OP_INSERT_BEFORE) ||
                          (op_ff == idll_pkg::OP_INSERT_AFTER) || is_del;
   assign sts.pos_bad = (pos_ff >= count_ff);
   assign sts.is_full = !is_del && (free_head_ff == '0);
   assign sts.walk_done = (walk_idx_ff == pos_ff);

   // free chain init sweep over every slot, the last one ends the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         init_done_ff <= 1'b0;
      end else if (cmd.clear_init && !init_done_ff) begin
         init_ff <= init_ff + 1'b1;
         if (init_ff == idll_pkg::slot_type'(idll_pkg::Capacity)) init_done_ff <= 1'b1;
      end
   end

   // request capture and walk cursor
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         value_ff <= req_value;
         pos_ff <= req_position;
         walk_idx_ff <= '0;
      end else if (cmd.walk_step) begin
         walk_idx_ff <= walk_idx_ff + 1'b1;
      end
   end

   idll_pkg::slot_type cursor_in;
   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.load) cursor_in = head_ff;
      else if (cmd.walk_step) cursor_in = walk_rd_ff;
   end
   always_ff @(posedge clock) cursor_ff <= cursor_in;

   // memory reads
   always_ff @(posedge clock) begin
      if (cmd.walk_read) walk_rd_ff <= next_mem[cursor_ff];
      if (cmd.link_read) begin
         anc_prev_ff <= prev_mem[cursor_ff];
         anc_next_ff <= next_mem[cursor_ff];
         anc_val_ff <= values_mem[cursor_ff];
         free_nx_ff <= free_mem[free_head_ff];
      end
   end

   // new slot neighbours
   idll_pkg::slot_type new_slot, lp, ln;
   always_comb begin
      new_slot = is_del ? cursor_ff : free_head_ff;
      lp = '0;
      ln = '0;
      case (op_ff)
         idll_pkg::OP_PUSH_FRONT:    begin lp = '0; ln = head_ff; end
         idll_pkg::OP_PUSH_BACK:     begin lp = tail_ff; ln = '0; end
         idll_pkg::OP_INSERT_BEFORE: begin lp = anc_prev_ff; ln = cursor_ff; end
         idll_pkg::OP_INSERT_AFTER:  begin lp = cursor_ff; ln = anc_next_ff; end
         default:                    begin lp = anc_prev_ff; ln = anc_next_ff; end
      endcase
   end

   // own links of an inserted slot are written the cycle after commit
   logic fold_ff;
   idll_pkg::slot_type fold_slot_ff, fold_p_ff, fold_n_ff;
   always_ff @(posedge clock) begin
      if (reset) fold_ff <= 1'b0;
      else fold_ff <= cmd.commit && !is_del;
      fold_slot_ff <= new_slot;
      fold_p_ff <= lp;
      fold_n_ff <= ln;
   end

   // link updates, one write port per array
   always_ff @(posedge clock) begin
      if (cmd.clear_init && !init_done_ff) begin
         free_mem[init_ff] <= (init_ff == '0 ||
                               init_ff == idll_pkg::slot_type'(idll_pkg::Capacity)) ?
                              '0 : init_ff + 1'b1;
      end else if (cmd.commit && is_del) begin
         free_mem[cursor_ff] <= free_head_ff;
      end
      if (cmd.commit) begin
         if (is_del) begin
            if (lp != '0) next_mem[lp] <= ln;
            if (ln != '0) prev_mem[ln] <= lp;
         end else begin
            values_mem[new_slot] <= value_ff;
            if (lp != '0) next_mem[lp] <= new_slot;
            if (ln != '0) prev_mem[ln] <= new_slot;
         end
      end else if (fold_ff) begin
         prev_mem[fold_slot_ff] <= fold_p_ff;
         next_mem[fold_slot_ff] <= fold_n_ff;
      end
   end

   // head, tail, free head, count and result
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; tail_ff <= '0;
         free_head_ff <= idll_pkg::slot_type'(1); count_ff <= '0;
      end else if (cmd.commit) begin
         if (is_del) begin
            if (lp == '0) head_ff <= ln;
            if (ln == '0) tail_ff <= lp;
            free_head_ff <= cursor_ff;
            count_ff <= count_ff - 1'b1;
         end else begin
            if (lp == '0) head_ff <= new_slot;
            if (ln == '0) tail_ff <= new_slot;
            free_head_ff <= free_nx_ff;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      res_status = idll_pkg::ST_OK;
      res_slot = '0;
      res_element = '0;
      res_count = count_ff;
      if (cmd.fail_pos) res_status = idll_pkg::ST_BAD_POS;
      else if (cmd.fail_full) res_status = idll_pkg::ST_FULL;
      else if (cmd.commit) begin
         res_slot = new_slot;
         res_element = is_del ? anc_val_ff : value_ff;
         res_count = is_del ? count_ff - 1'b1 : count_ff + 1'b1;
      end
   end

endmodule

/* design/indexed_doubly_linked_list_engine.sv */
// top level of the indexed doubly linked list engine
// a doubly linked list of up to 255 elements held in slot arrays 1..255 with a
// free chain; slot 0 is the null link. after reset a free chain init pass runs
// before the first transaction is taken. push front and push back go from
// accept through check, link read and commit to their result; insert and
// delete at position 0 go the same way, and at position p above 0 first walk
// p steps from the head, each step being one registered read of the next link
// array plus a cursor update. one transaction is in work at a time and the
// next one can be taken the cycle after the result is loaded. the result
// register parts the two sides: a new transaction is accepted while the
// previous result waits, and the engine holds its last step until that result
// is taken. failing requests (bad position, full) and unknown codes answer
// from the check step and leave the state alone.
module indexed_doubly_linked_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], value[34:3], position[42:35], zero fill to 48
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], slot[9:2], element[41:10], count[49:42], zero fill to 56
   output logic [55:0] rsp_tdata
);

   idll_pkg::cmd_type cmd;
   idll_pkg::sts_type sts;
   logic rsp_load, req_fire, rsp_free;
   logic [1:0] res_status;
   idll_pkg::slot_type res_slot, res_count;
   idll_pkg::value_type res_element;
   logic rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   // result register takes a new result when empty or drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   idll_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_free, .sts, .cmd, .req_tready, .rsp_load
   );

   idll_dpath u_dpath (
      .clock, .reset, .cmd,
      .req_operation(req_tdata[2:0]),
      .req_value(req_tdata[34:3]),
      .req_position(req_tdata[42:35]),
      .sts, .res_status, .res_slot, .res_element, .res_count
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (rsp_load) rsp_data_ff <= {6'd0, res_count, res_element, res_slot, res_status};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
